>>> rtl/core/pstc_pkg.sv
// pstc_pkg: shared sizes, payload structs, controller states and the
// command / status bundles of the priority scheduling block
// no dependencies
package pstc_pkg;

  // configuration of the block
  localparam int MAX_PROCESSES = 16;
  localparam int BURST_BITS    = 16;
  localparam int PRIORITY_BITS = 8;

  // derived sizes
  localparam int IDX_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
  localparam int KEY_W   = PRIORITY_BITS + IDX_W;
  localparam int ENTRY_W = PRIORITY_BITS + BURST_BITS;
  localparam int ACC_W   = BURST_BITS + CNT_W;
  localparam int TOT_W   = BURST_BITS + 2 * CNT_W;
  localparam int NUM_W   = TOT_W + 8;
  localparam int DEN_W   = CNT_W + 1;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  // averages are reported in hundredths, rounded half up: (2*100*sum + n) / 2n
  localparam int AVG_SCALE = 200;

  typedef struct packed {
    logic [15:0] burst_time;
    logic [7:0]  priority_req;
    logic        last_process;
  } proc_item_t;

  typedef struct packed {
    logic [4:0]  process_id;
    logic [7:0]  priority_out;
    logic [15:0] burst_out;
    logic [19:0] waiting_time;
    logic [19:0] turnaround_time;
    logic        is_summary;
    logic [26:0] avg_waiting_x100;
    logic [26:0] avg_turnaround_x100;
    logic        capacity_exceeded;
    logic        last;
  } res_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT,
    ST_DIV_W,
    ST_WAIT_W,
    ST_DIV_T,
    ST_WAIT_T,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic load;
    logic run_init;
    logic scan;
    logic scan_start;
    logic emit;
    logic div_start;
    logic div_sel_t;
    logic capture_w;
    logic capture_t;
    logic summary;
  } ctrl_cmd_t;

  typedef struct packed {
    logic load_last;
    logic scan_done;
    logic last_pass;
    logic out_free;
    logic div_done;
  } dp_status_t;

endpackage

>>> rtl/core/pstc_ram.sv
// pstc_ram: generic single write port, single read port memory with
// registered read data; no dependencies
module pstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pstc_div.sv
// pstc_div: restoring divider, one quotient bit per cycle
// depends on pstc_pkg for operand widths
module pstc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pstc_pkg::NUM_W-1:0] numer,
  input  logic [pstc_pkg::DEN_W-1:0] denom,
  output logic                       busy,
  output logic                       done,
  output logic [pstc_pkg::NUM_W-1:0] quot
);

  logic [pstc_pkg::DEN_W-1:0]  rem;
  logic [pstc_pkg::DEN_W-1:0]  den_r;
  logic [pstc_pkg::NUM_W-1:0]  work;
  logic [pstc_pkg::STEP_W-1:0] step;
  logic [pstc_pkg::DEN_W:0]    trial;
  logic [pstc_pkg::DEN_W:0]    diff;
  logic                        ge;

  // one trial subtraction per step
  always_comb begin
    trial = {rem, work[pstc_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (step == pstc_pkg::STEP_W'(pstc_pkg::NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // operands, partial remainder and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      work  <= numer;
      den_r <= denom;
      rem   <= '0;
      step  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[pstc_pkg::DEN_W-1:0] : trial[pstc_pkg::DEN_W-1:0];
      work <= {work[pstc_pkg::NUM_W-2:0], ge};
      step <= step + pstc_pkg::STEP_W'(1);
    end
  end

  assign quot = work;

endmodule

>>> rtl/core/pstc_dp.sv
// pstc_dp: process store, selection scan, time accumulation, averaging
// and result register; depends on pstc_pkg, pstc_ram and pstc_div
module pstc_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  pstc_pkg::ctrl_cmd_t    cmd,
  output pstc_pkg::dp_status_t   st,
  input  pstc_pkg::proc_item_t   proc_item,
  output logic                   res_valid,
  input  logic                   res_ready,
  output pstc_pkg::res_item_t    res_item
);

  logic [pstc_pkg::CNT_W-1:0]      count;
  logic                            overflow;
  logic [pstc_pkg::CNT_W-1:0]      scan_addr;
  logic [pstc_pkg::CNT_W-1:0]      emitted;
  logic [pstc_pkg::CNT_W-1:0]      emitted_inc;
  logic                            rd_issue;
  logic                            rd_valid;
  logic [pstc_pkg::IDX_W-1:0]      rd_idx;
  logic [pstc_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [pstc_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [pstc_pkg::KEY_W-1:0]      cand_key;
  logic [pstc_pkg::BURST_BITS-1:0] cand_burst;
  logic                            take;
  logic [pstc_pkg::KEY_W-1:0]      prev_key;
  logic                            prev_valid;
  logic [pstc_pkg::KEY_W-1:0]      best_key;
  logic [pstc_pkg::BURST_BITS-1:0] best_burst;
  logic                            best_valid;
  logic [pstc_pkg::ACC_W-1:0]      acc;
  logic [pstc_pkg::ACC_W-1:0]      turn;
  logic [pstc_pkg::TOT_W-1:0]      totw;
  logic [pstc_pkg::TOT_W-1:0]      tott;
  logic [pstc_pkg::TOT_W-1:0]      tot_sel;
  logic [pstc_pkg::NUM_W-1:0]      avg_w;
  logic [pstc_pkg::NUM_W-1:0]      avg_t;
  logic [pstc_pkg::NUM_W-1:0]      div_numer;
  logic [pstc_pkg::DEN_W-1:0]      div_denom;
  logic [pstc_pkg::NUM_W-1:0]      div_quot;
  logic                            div_busy;
  logic                            div_done;
  logic                            out_free;
  pstc_pkg::res_item_t             res_next;

  // process store: priority above burst in one word per entry
  assign ram_wdata = {pstc_pkg::PRIORITY_BITS'(proc_item.priority_req),
                      pstc_pkg::BURST_BITS'(proc_item.burst_time)};

  pstc_ram #(
    .WIDTH (pstc_pkg::ENTRY_W),
    .DEPTH (pstc_pkg::MAX_PROCESSES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load && (count < pstc_pkg::CNT_W'(pstc_pkg::MAX_PROCESSES))),
    .waddr (count[pstc_pkg::IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (scan_addr[pstc_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // scan compare: smallest {priority, arrival} key above the one last served
  always_comb begin
    rd_issue   = cmd.scan && (scan_addr < count);
    cand_key   = {ram_rdata[pstc_pkg::ENTRY_W-1 -: pstc_pkg::PRIORITY_BITS], rd_idx};
    cand_burst = ram_rdata[pstc_pkg::BURST_BITS-1:0];
    take       = rd_valid && (!prev_valid || (cand_key > prev_key)) &&
                 (!best_valid || (cand_key < best_key));
  end

  // times of the selected process and result formatting
  always_comb begin
    turn        = acc + pstc_pkg::ACC_W'(best_burst);
    emitted_inc = emitted + pstc_pkg::CNT_W'(1);
    out_free    = !res_valid || res_ready;
    res_next    = '0;
    if (cmd.summary) begin
      res_next.is_summary          = 1'b1;
      res_next.avg_waiting_x100    = 27'(avg_w);
      res_next.avg_turnaround_x100 = 27'(avg_t);
      res_next.capacity_exceeded   = overflow;
      res_next.last                = 1'b1;
    end else begin
      res_next.process_id      = 5'(pstc_pkg::CNT_W'(best_key[pstc_pkg::IDX_W-1:0]) +
                                     pstc_pkg::CNT_W'(1));
      res_next.priority_out    = 8'(best_key[pstc_pkg::KEY_W-1 -: pstc_pkg::PRIORITY_BITS]);
      res_next.burst_out       = 16'(best_burst);
      res_next.waiting_time    = 20'(acc);
      res_next.turnaround_time = 20'(turn);
    end
  end

  // averaging operands: (sum * 200 + n) / 2n
  always_comb begin
    tot_sel   = cmd.div_sel_t ? tott : totw;
    div_numer = pstc_pkg::NUM_W'(tot_sel) * pstc_pkg::NUM_W'(pstc_pkg::AVG_SCALE) +
                pstc_pkg::NUM_W'(count);
    div_denom = {count, 1'b0};
  end

  pstc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflow   <= 1'b0;
      scan_addr  <= '0;
      rd_valid   <= 1'b0;
      best_valid <= 1'b0;
      prev_valid <= 1'b0;
      emitted    <= '0;
      res_valid  <= 1'b0;
    end else begin
      // fill count and capacity flag
      if (cmd.load) begin
        if (count < pstc_pkg::CNT_W'(pstc_pkg::MAX_PROCESSES)) begin
          count <= count + pstc_pkg::CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end else if (cmd.summary) begin
        count    <= '0;
        overflow <= 1'b0;
      end
      // scan address and read pipeline
      if (cmd.run_init || cmd.scan_start) begin
        scan_addr  <= '0;
        rd_valid   <= 1'b0;
        best_valid <= 1'b0;
      end else begin
        rd_valid <= rd_issue;
        if (rd_issue) begin
          scan_addr <= scan_addr + pstc_pkg::CNT_W'(1);
        end
        if (take) begin
          best_valid <= 1'b1;
        end
      end
      // service progress
      if (cmd.run_init) begin
        prev_valid <= 1'b0;
        emitted    <= '0;
      end else if (cmd.emit) begin
        prev_valid <= 1'b1;
        emitted    <= emitted_inc;
      end
      // result register
      if (cmd.emit || cmd.summary) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr[pstc_pkg::IDX_W-1:0];
    if (take) begin
      best_key   <= cand_key;
      best_burst <= cand_burst;
    end
    if (cmd.run_init) begin
      acc  <= '0;
      totw <= '0;
      tott <= '0;
    end else if (cmd.emit) begin
      acc      <= turn;
      totw     <= totw + pstc_pkg::TOT_W'(acc);
      tott     <= tott + pstc_pkg::TOT_W'(turn);
      prev_key <= best_key;
    end
    if (cmd.capture_w && div_done) begin
      avg_w <= div_quot;
    end
    if (cmd.capture_t && div_done) begin
      avg_t <= div_quot;
    end
    if (cmd.emit || cmd.summary) begin
      res_item <= res_next;
    end
  end

  // status to the controller
  always_comb begin
    st.load_last = proc_item.last_process;
    st.scan_done = (scan_addr == count) && !rd_valid;
    st.last_pass = (emitted_inc == count);
    st.out_free  = out_free;
    st.div_done  = div_done;
  end

  // checks
  a_emit_winner: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> best_valid && out_free)
    else $error("result issued without a selected process");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pstc_pkg::CNT_W'(pstc_pkg::MAX_PROCESSES))
    else $error("fill count beyond capacity");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (pstc_pkg::CNT_W'(rd_idx) < count))
    else $error("scan read beyond stored processes");

endmodule

>>> rtl/core/pstc_ctrl.sv
// pstc_ctrl: run sequencer for load, selection scans, result issue,
// averaging and summary; depends on pstc_pkg
module pstc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 proc_valid,
  output logic                 proc_ready,
  input  pstc_pkg::dp_status_t st,
  output pstc_pkg::ctrl_cmd_t  cmd
);

  pstc_pkg::state_t state;
  pstc_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pstc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pstc_pkg::ST_LOAD: begin
        if (proc_valid && st.load_last) state_next = pstc_pkg::ST_SCAN;
      end
      pstc_pkg::ST_SCAN: begin
        if (st.scan_done) state_next = pstc_pkg::ST_EMIT;
      end
      pstc_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_next = st.last_pass ? pstc_pkg::ST_DIV_W : pstc_pkg::ST_SCAN;
        end
      end
      pstc_pkg::ST_DIV_W: begin
        state_next = pstc_pkg::ST_WAIT_W;
      end
      pstc_pkg::ST_WAIT_W: begin
        if (st.div_done) state_next = pstc_pkg::ST_DIV_T;
      end
      pstc_pkg::ST_DIV_T: begin
        state_next = pstc_pkg::ST_WAIT_T;
      end
      pstc_pkg::ST_WAIT_T: begin
        if (st.div_done) state_next = pstc_pkg::ST_SUMMARY;
      end
      pstc_pkg::ST_SUMMARY: begin
        if (st.out_free) state_next = pstc_pkg::ST_LOAD;
      end
      default: begin
        state_next = pstc_pkg::ST_LOAD;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    proc_ready = 1'b0;
    unique case (state)
      pstc_pkg::ST_LOAD: begin
        proc_ready   = 1'b1;
        cmd.load     = proc_valid;
        cmd.run_init = proc_valid && st.load_last;
      end
      pstc_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      pstc_pkg::ST_EMIT: begin
        cmd.emit       = st.out_free;
        cmd.scan_start = st.out_free && !st.last_pass;
      end
      pstc_pkg::ST_DIV_W: begin
        cmd.div_start = 1'b1;
      end
      pstc_pkg::ST_WAIT_W: begin
        cmd.capture_w = 1'b1;
      end
      pstc_pkg::ST_DIV_T: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_t = 1'b1;
      end
      pstc_pkg::ST_WAIT_T: begin
        cmd.capture_t = 1'b1;
        cmd.div_sel_t = 1'b1;
      end
      pstc_pkg::ST_SUMMARY: begin
        cmd.summary = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/priority_schedule_time_calc.sv
// Non-preemptive priority scheduler: one process transfer per cycle while loading.
// After the last process each result needs a scan of the process store (a store read per
// stored process, the registered read, scan end) and an issue that waits for a free result
// register; the two averages then run in turn through the shared divider, then the summary.
// Reset clears fill count, capacity flag, sequencer and result register; the process
// store has no reset and is read only where written. Depends on pstc_pkg, pstc_ctrl, pstc_dp
module priority_schedule_time_calc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 proc_valid,
  output logic                 proc_ready,
  input  pstc_pkg::proc_item_t proc_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pstc_pkg::res_item_t  res_item
);

  pstc_pkg::ctrl_cmd_t  cmd;
  pstc_pkg::dp_status_t st;

  // sequencer
  pstc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .proc_valid (proc_valid),
    .proc_ready (proc_ready),
    .st         (st),
    .cmd        (cmd)
  );

  // datapath
  pstc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .proc_item (proc_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule
